// ===== rtl/tssd_pkg.sv =====
// ----------------------------------------------------------------------------
// tssd_pkg
// Shared types, constants and helper functions of the touch slider swipe
// detector.
// ----------------------------------------------------------------------------
package tssd_pkg;

  localparam int unsigned SENSORS_DEF      = 8;
  localparam int unsigned READING_BITS_DEF = 16;

  localparam int unsigned MASK_W   = 8;
  localparam int unsigned COUNT_W  = 9;
  localparam int unsigned THRESH_W = 16;
  localparam int unsigned USED_W   = 4;
  localparam int unsigned TIMEOUT_W = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [COUNT_W-1:0]   COUNT_MAX          = 9'd511;
  localparam logic [THRESH_W-1:0]  THRESHOLD_RESET    = 16'hFFFF;
  localparam logic [USED_W-1:0]    SENSORS_USED_RESET = 4'd8;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET      = 8'd40;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SENSORS_USED  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_LIMIT = 2'd2;

  typedef enum logic [1:0] {
    SWIPE_NONE  = 2'd0,
    SWIPE_LEFT  = 2'd1,
    SWIPE_RIGHT = 2'd2
  } swipe_e;

  typedef struct packed {
    swipe_e               swipe;
    logic [COUNT_W-1:0]   speed;
  } gesture_t;

  function automatic logic [2:0] low_bit(input logic [MASK_W-1:0] m);
    logic [2:0] r;
    r = 3'd0;
    for (int i = MASK_W - 1; i >= 0; i--) begin
      if (m[i]) begin
        r = 3'(i);
      end
    end
    return r;
  endfunction

  function automatic logic [2:0] high_bit(input logic [MASK_W-1:0] m);
    logic [2:0] r;
    r = 3'd0;
    for (int i = 0; i < MASK_W; i++) begin
      if (m[i]) begin
        r = 3'(i);
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/touch_slider_swipe_detector_core.sv =====
// ----------------------------------------------------------------------------
// touch_slider_swipe_detector_core
// Top level: configuration registers, input register, mask and gesture logic,
// result register.
// ----------------------------------------------------------------------------
// The block takes one scan per clock cycle unless the output stalls, and
// returns one result per scan, in order. A scan passes through an input
// register and then a result register on its way to the output. Threshold
// compare, priority encoding and the counter update all settle
// combinationally between those two registers.
module touch_slider_swipe_detector_core #(
  parameter int unsigned SENSORS      = tssd_pkg::SENSORS_DEF,
  parameter int unsigned READING_BITS = tssd_pkg::READING_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tssd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [tssd_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [READING_BITS-1:0]           reading_0_i,
  input  logic [READING_BITS-1:0]           reading_1_i,
  input  logic [READING_BITS-1:0]           reading_2_i,
  input  logic [READING_BITS-1:0]           reading_3_i,
  input  logic [READING_BITS-1:0]           reading_4_i,
  input  logic [READING_BITS-1:0]           reading_5_i,
  input  logic [READING_BITS-1:0]           reading_6_i,
  input  logic [READING_BITS-1:0]           reading_7_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [1:0]                        swipe_o,
  output logic [tssd_pkg::COUNT_W-1:0]      swipe_speed_o,
  output logic [tssd_pkg::MASK_W-1:0]       touch_mask_o
);

  logic [tssd_pkg::THRESH_W-1:0]  threshold_q;
  logic [tssd_pkg::USED_W-1:0]    sensors_used_q;
  logic [tssd_pkg::TIMEOUT_W-1:0] timeout_q;

  logic                                         in_valid_q;
  logic [tssd_pkg::MASK_W-1:0][READING_BITS-1:0] readings_q;
  logic                                         out_valid_q;
  tssd_pkg::gesture_t                           gesture_q;
  logic [tssd_pkg::MASK_W-1:0]                  mask_q;

  logic                        advance;
  logic [tssd_pkg::MASK_W-1:0] mask;
  tssd_pkg::gesture_t          gesture;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q    <= tssd_pkg::THRESHOLD_RESET;
      sensors_used_q <= tssd_pkg::SENSORS_USED_RESET;
      timeout_q      <= tssd_pkg::TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tssd_pkg::REG_THRESHOLD: begin
          threshold_q <= cfg_data_i[tssd_pkg::THRESH_W-1:0];
        end
        tssd_pkg::REG_SENSORS_USED: begin
          sensors_used_q <= cfg_data_i[tssd_pkg::USED_W-1:0];
        end
        tssd_pkg::REG_TIMEOUT_LIMIT: begin
          timeout_q <= cfg_data_i[tssd_pkg::TIMEOUT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      readings_q <= {reading_7_i, reading_6_i, reading_5_i, reading_4_i,
                     reading_3_i, reading_2_i, reading_1_i, reading_0_i};
    end
    if (advance && in_valid_q) begin
      gesture_q <= gesture;
      mask_q    <= mask;
    end
  end

  tssd_mask #(
    .SENSORS      (SENSORS),
    .READING_BITS (READING_BITS)
  ) u_mask (
    .readings_i     (readings_q),
    .threshold_i    (threshold_q),
    .sensors_used_i (sensors_used_q),
    .mask_o         (mask)
  );

  tssd_gesture u_gesture (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (advance && in_valid_q),
    .mask_i    (mask),
    .timeout_i (timeout_q),
    .result_o  (gesture)
  );

  assign out_valid_o   = out_valid_q;
  assign swipe_o       = gesture_q.swipe;
  assign swipe_speed_o = gesture_q.speed;
  assign touch_mask_o  = mask_q;

  a_speed_only_on_swipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (swipe_o == tssd_pkg::SWIPE_NONE) |-> swipe_speed_o == '0)
    else $error("swipe speed reported without a swipe");

  a_mask_within_sensors: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (touch_mask_o >> SENSORS) == '0)
    else $error("touch mask has bits beyond the sensor count");

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled without a held request");

  a_swipe_code_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (swipe_o == tssd_pkg::SWIPE_NONE) ||
                    (swipe_o == tssd_pkg::SWIPE_LEFT) ||
                    (swipe_o == tssd_pkg::SWIPE_RIGHT))
    else $error("illegal swipe code");

endmodule

// ===== rtl/tssd_mask.sv =====
// ----------------------------------------------------------------------------
// tssd_mask
// Compares each reading against the threshold and builds the touch mask of
// the sensors in use.
// ----------------------------------------------------------------------------
module tssd_mask #(
  parameter int unsigned SENSORS      = tssd_pkg::SENSORS_DEF,
  parameter int unsigned READING_BITS = tssd_pkg::READING_BITS_DEF
) (
  input  logic [tssd_pkg::MASK_W-1:0][READING_BITS-1:0] readings_i,
  input  logic [tssd_pkg::THRESH_W-1:0]                 threshold_i,
  input  logic [tssd_pkg::USED_W-1:0]                   sensors_used_i,
  output logic [tssd_pkg::MASK_W-1:0]                   mask_o
);

  localparam logic [tssd_pkg::USED_W-1:0] SensorsMax = tssd_pkg::USED_W'(SENSORS);

  logic [tssd_pkg::USED_W-1:0] used;

  always_comb begin
    used = (sensors_used_i > SensorsMax) ? SensorsMax : sensors_used_i;
    for (int i = 0; i < tssd_pkg::MASK_W; i++) begin
      mask_o[i] = (tssd_pkg::USED_W'(i) < used) &&
                  (32'(readings_i[i]) > 32'(threshold_i));
    end
  end

endmodule

// ===== rtl/tssd_gesture.sv =====
// ----------------------------------------------------------------------------
// tssd_gesture
// Gesture tracker: armed mask, speed and idle counters, and the swipe
// decision for one scan.
// ----------------------------------------------------------------------------
module tssd_gesture (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic [tssd_pkg::MASK_W-1:0]     mask_i,
  input  logic [tssd_pkg::TIMEOUT_W-1:0]  timeout_i,
  output tssd_pkg::gesture_t              result_o
);

  logic [tssd_pkg::MASK_W-1:0]  armed_q, armed_d;
  logic [tssd_pkg::COUNT_W-1:0] speed_q, speed_d;
  logic [tssd_pkg::COUNT_W-1:0] idle_q, idle_d;
  logic [tssd_pkg::COUNT_W-1:0] speed_inc, idle_inc;
  logic                         left, right;

  always_comb begin
    armed_d = armed_q;
    speed_d = speed_q;
    idle_d  = idle_q;
    result_o.swipe = tssd_pkg::SWIPE_NONE;
    result_o.speed = '0;
    speed_inc = (speed_q < tssd_pkg::COUNT_MAX) ? speed_q + 1'b1 : speed_q;
    idle_inc  = (idle_q < tssd_pkg::COUNT_MAX) ? idle_q + 1'b1 : idle_q;
    left  = (mask_i != '0) &&
            (tssd_pkg::low_bit(mask_i) < tssd_pkg::low_bit(armed_q));
    right = (mask_i != '0) && !left &&
            (tssd_pkg::high_bit(mask_i) > tssd_pkg::high_bit(armed_q));
    if (armed_q == '0) begin
      if (mask_i != '0) begin
        armed_d = mask_i;
        speed_d = '0;
        idle_d  = '0;
      end
    end else if (left) begin
      result_o.swipe = tssd_pkg::SWIPE_LEFT;
      result_o.speed = speed_inc;
      armed_d = mask_i;
      speed_d = '0;
      idle_d  = '0;
    end else if (right) begin
      result_o.swipe = tssd_pkg::SWIPE_RIGHT;
      result_o.speed = speed_inc;
      armed_d = mask_i;
      speed_d = '0;
    end else if (idle_inc > tssd_pkg::COUNT_W'(timeout_i)) begin
      armed_d = '0;
      speed_d = '0;
      idle_d  = '0;
    end else begin
      speed_d = speed_inc;
      idle_d  = idle_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= '0;
      speed_q <= '0;
      idle_q  <= '0;
    end else if (en_i) begin
      armed_q <= armed_d;
      speed_q <= speed_d;
      idle_q  <= idle_d;
    end
  end

endmodule

// ===== verif/tb_touch_slider_swipe_detector_core.sv =====
// ----------------------------------------------------------------------------
// tb_touch_slider_swipe_detector_core
// Self-checking testbench for the touch slider swipe detector core.
// A queue of scans is sent through the input port in random bursts, while
// the output side stalls on its own random pattern. One long hold-off fills
// the block up. A local model of the mask, arming, swipe and timeout logic
// predicts every result, and each result is checked field by field in order.
// The run covers a directed set of extremes, then random swipe gestures and
// noise under several register settings.
// ----------------------------------------------------------------------------
module tb_touch_slider_swipe_detector_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RB         = tssd_pkg::READING_BITS_DEF;
  localparam int unsigned CYCLE_CAP  = 400000;
  localparam logic [tssd_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

  typedef logic [7:0][RB-1:0] scan_t;

  typedef struct packed {
    tssd_pkg::swipe_e                swipe;
    logic [tssd_pkg::COUNT_W-1:0]    speed;
    logic [tssd_pkg::MASK_W-1:0]     mask;
  } gesture_result_t;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_we;
  logic [tssd_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [tssd_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                            in_valid;
  logic                            in_stall_o;
  logic [RB-1:0]                   rd [8];
  logic                            out_valid_o;
  logic                            out_stall;
  logic [1:0]                      swipe_o;
  logic [tssd_pkg::COUNT_W-1:0]    swipe_speed_o;
  logic [tssd_pkg::MASK_W-1:0]     touch_mask_o;

  touch_slider_swipe_detector_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall_o),
    .reading_0_i   (rd[0]),
    .reading_1_i   (rd[1]),
    .reading_2_i   (rd[2]),
    .reading_3_i   (rd[3]),
    .reading_4_i   (rd[4]),
    .reading_5_i   (rd[5]),
    .reading_6_i   (rd[6]),
    .reading_7_i   (rd[7]),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall),
    .swipe_o       (swipe_o),
    .swipe_speed_o (swipe_speed_o),
    .touch_mask_o  (touch_mask_o)
  );

  scan_t           pending_scans[$];
  gesture_result_t expected_gestures[$];
  scan_t           cur_scan;
  bit              scan_held;
  int              burst_left;
  int              gap_left;
  int              hold_left;
  int              pat_left;
  int              stall_pct;
  bit              pressure_req;
  bit              pressure_done;
  int              scans_queued;
  int              scans_taken;
  int              results_checked;
  int              lefts_seen;
  int              rights_seen;
  int              err_cnt;
  int              settings_cnt;
  int unsigned     cycle_cnt;

  logic [tssd_pkg::THRESH_W-1:0]  cfg_thr;
  logic [tssd_pkg::USED_W-1:0]    cfg_used;
  logic [tssd_pkg::TIMEOUT_W-1:0] cfg_tmo;
  logic [tssd_pkg::MASK_W-1:0]    arm_mask;
  logic [tssd_pkg::COUNT_W-1:0]   speed_cnt;
  logic [tssd_pkg::COUNT_W-1:0]   idle_cnt;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int used_eff();
    return (cfg_used > 8) ? 8 : int'(cfg_used);
  endfunction

  function automatic int lowest_bit(input logic [tssd_pkg::MASK_W-1:0] m);
    int r;
    r = 8;
    for (int i = tssd_pkg::MASK_W - 1; i >= 0; i--) begin
      if (m[i]) begin
        r = i;
      end
    end
    return r;
  endfunction

  function automatic int highest_bit(input logic [tssd_pkg::MASK_W-1:0] m);
    int r;
    r = 0;
    for (int i = 0; i < tssd_pkg::MASK_W; i++) begin
      if (m[i]) begin
        r = i;
      end
    end
    return r;
  endfunction

  task automatic predict_gesture(input scan_t s);
    logic [tssd_pkg::MASK_W-1:0] m;
    gesture_result_t             r;
    int                          n;
    n = used_eff();
    m = '0;
    for (int i = 0; i < n; i++) begin
      if (s[i] > cfg_thr) begin
        m[i] = 1'b1;
      end
    end
    r.swipe = tssd_pkg::SWIPE_NONE;
    r.speed = '0;
    r.mask  = m;
    if (arm_mask == '0) begin
      if (m != '0) begin
        speed_cnt = '0;
        idle_cnt  = '0;
        arm_mask  = m;
      end
    end else begin
      if (speed_cnt != tssd_pkg::COUNT_MAX) begin
        speed_cnt = speed_cnt + 1'b1;
      end
      if (m != '0 && lowest_bit(m) < lowest_bit(arm_mask)) begin
        r.swipe   = tssd_pkg::SWIPE_LEFT;
        r.speed   = speed_cnt;
        speed_cnt = '0;
        idle_cnt  = '0;
        arm_mask  = m;
      end else if (m != '0 && highest_bit(m) > highest_bit(arm_mask)) begin
        r.swipe   = tssd_pkg::SWIPE_RIGHT;
        r.speed   = speed_cnt;
        speed_cnt = '0;
        arm_mask  = m;
      end else begin
        if (idle_cnt != tssd_pkg::COUNT_MAX) begin
          idle_cnt = idle_cnt + 1'b1;
        end
        if (idle_cnt > cfg_tmo) begin
          speed_cnt = '0;
          idle_cnt  = '0;
          arm_mask  = '0;
        end
      end
    end
    expected_gestures.push_back(r);
  endtask

  function automatic scan_t make_scan(input logic [tssd_pkg::MASK_W-1:0] m);
    scan_t s;
    int    n;
    n = used_eff();
    for (int i = 0; i < 8; i++) begin
      if (i >= n) begin
        s[i] = RB'($urandom());
      end else if (m[i] && cfg_thr != '1) begin
        s[i] = RB'($urandom_range(int'(cfg_thr) + 1, 65535));
      end else begin
        s[i] = RB'($urandom_range(0, int'(cfg_thr)));
      end
    end
    return s;
  endfunction

  task automatic push_scan(input scan_t s);
    pending_scans.push_back(s);
    scans_queued++;
  endtask

  task automatic write_reg(input logic [tssd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tssd_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = data;
    case (idx)
      tssd_pkg::REG_THRESHOLD:     cfg_thr  = data[tssd_pkg::THRESH_W-1:0];
      tssd_pkg::REG_SENSORS_USED:  cfg_used = data[tssd_pkg::USED_W-1:0];
      tssd_pkg::REG_TIMEOUT_LIMIT: cfg_tmo  = data[tssd_pkg::TIMEOUT_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  task automatic drain();
    while (pending_scans.size() != 0 || scan_held ||
           expected_gestures.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(negedge clk_i);
  endtask

  task automatic configure(input logic [15:0] thr, input logic [15:0] used,
                           input logic [15:0] tmo);
    drain();
    write_reg(tssd_pkg::REG_THRESHOLD, thr);
    write_reg(tssd_pkg::REG_SENSORS_USED, used);
    write_reg(tssd_pkg::REG_TIMEOUT_LIMIT, tmo);
    settings_cnt++;
  endtask

  task automatic queue_gesture();
    int                          n;
    int                          w;
    int                          p;
    int                          steps;
    int                          rel;
    logic [tssd_pkg::MASK_W-1:0] m;
    n = used_eff();
    w = $urandom_range(1, (n < 3) ? n : 3);
    p = $urandom_range(0, n - w);
    steps = $urandom_range(1, 6);
    for (int k = 0; k <= steps; k++) begin
      m = tssd_pkg::MASK_W'(((1 << w) - 1) << p);
      if ($urandom_range(0, 9) == 0) begin
        m = tssd_pkg::MASK_W'($urandom());
      end
      push_scan(make_scan(m));
      if ($urandom_range(0, 3) == 0) begin
        push_scan(make_scan(m));
      end
      if ($urandom_range(0, 1) == 1) begin
        if (p + w < n) p++;
      end else if (p > 0) begin
        p--;
      end
      if ($urandom_range(0, 4) == 0) begin
        w = $urandom_range(1, (n - p < 3) ? n - p : 3);
      end
    end
    if (cfg_tmo < 64 && $urandom_range(0, 4) == 0) begin
      rel = int'(cfg_tmo) + $urandom_range(1, 3);
    end else begin
      rel = $urandom_range(0, 3);
    end
    repeat (rel) push_scan(make_scan('0));
  endtask

  task automatic queue_random(input int count);
    int   base;
    scan_t s;
    base = scans_queued;
    while (scans_queued - base < count) begin
      if (used_eff() > 0 && $urandom_range(0, 9) < 7) begin
        queue_gesture();
      end else if ($urandom_range(0, 1) == 0) begin
        for (int i = 0; i < 8; i++) begin
          s[i] = RB'($urandom());
        end
        push_scan(s);
      end else begin
        push_scan(make_scan(tssd_pkg::MASK_W'($urandom())));
      end
    end
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(negedge clk_i) begin
    if (rst_ni && !scan_held) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid = 1'b0;
      end else if (pending_scans.size() != 0) begin
        cur_scan = pending_scans.pop_front();
        for (int i = 0; i < 8; i++) begin
          rd[i] = cur_scan[i];
        end
        in_valid  = 1'b1;
        scan_held = 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_valid = 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (in_valid && !in_stall_o) begin
      predict_gesture(cur_scan);
      scan_held = 1'b0;
      scans_taken++;
    end
  end

  // Receiver: stall density changes in stretches; one long hold-off on request.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall = 1'b1;
    end else if (pressure_req && !pressure_done) begin
      pressure_done = 1'b1;
      hold_left     = 250;
      out_stall     = 1'b1;
    end else begin
      if (pat_left <= 0) begin
        pat_left = $urandom_range(16, 96);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 10;
          2: stall_pct = 40;
          default: stall_pct = 75;
        endcase
      end
      pat_left--;
      out_stall = ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    gesture_result_t e;
    if (rst_ni && out_valid_o && !out_stall) begin
      if (swipe_o == tssd_pkg::SWIPE_LEFT) lefts_seen++;
      if (swipe_o == tssd_pkg::SWIPE_RIGHT) rights_seen++;
      if (expected_gestures.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) begin
          $display("unexpected result: swipe %0d speed %0d mask %02h",
                   swipe_o, swipe_speed_o, touch_mask_o);
        end
      end else begin
        e = expected_gestures.pop_front();
        results_checked++;
        if (swipe_o != e.swipe || swipe_speed_o != e.speed ||
            touch_mask_o != e.mask) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display({"mismatch: swipe exp %0d got %0d, speed exp %0d got %0d, ",
                      "mask exp %02h got %02h"},
                     e.swipe, swipe_o, e.speed, swipe_speed_o, e.mask, touch_mask_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("tb_touch_slider_swipe_detector_core: done, errors");
      $finish;
    end
  end

  initial begin
    scan_t s;
    rst_ni    = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    out_stall = 1'b0;
    for (int i = 0; i < 8; i++) begin
      rd[i] = '0;
    end
    cur_scan      = '0;
    scan_held     = 1'b0;
    burst_left    = 1;
    gap_left      = 0;
    hold_left     = 0;
    pat_left      = 0;
    stall_pct     = 0;
    pressure_req  = 1'b0;
    pressure_done = 1'b0;
    scans_queued  = 0;
    scans_taken   = 0;
    results_checked = 0;
    lefts_seen    = 0;
    rights_seen   = 0;
    err_cnt       = 0;
    settings_cnt  = 1;
    cycle_cnt     = 0;
    cfg_thr       = tssd_pkg::THRESHOLD_RESET;
    cfg_used      = tssd_pkg::SENSORS_USED_RESET;
    cfg_tmo       = tssd_pkg::TIMEOUT_RESET;
    arm_mask      = '0;
    speed_cnt     = '0;
    idle_cnt      = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset threshold is the largest reading, so nothing counts as touched.
    push_scan('1);
    push_scan('0);

    configure(16'd1000, 16'd8, 16'd3);
    push_scan('0);
    push_scan('1);
    for (int i = 0; i < 8; i++) begin
      s[i] = RB'(1000);
    end
    push_scan(s);
    s = '0;
    s[5] = RB'(1001);
    push_scan(s);
    push_scan(make_scan(8'h00));
    push_scan(make_scan(8'h00));
    push_scan(make_scan(8'h18));
    push_scan(make_scan(8'h0C));
    push_scan(make_scan(8'h06));
    push_scan(make_scan(8'h0E));
    push_scan(make_scan(8'h0E));
    push_scan(make_scan(8'h80));
    push_scan(make_scan(8'h01));
    push_scan(make_scan(8'hFF));
    repeat (4) push_scan(make_scan(8'h00));

    configure(16'd0, 16'd8, 16'd40);
    queue_random(40);

    drain();
    write_reg(REG_UNMAPPED, 16'($urandom()));
    configure(16'd20000, 16'hFFF0, 16'h12FF);
    queue_random(20);

    // The largest timeout: 255 idle scans keep the touch armed, 256 do not.
    configure(16'd30000, 16'h000F, 16'd255);
    push_scan(make_scan(8'h10));
    repeat (255) push_scan(make_scan(8'h00));
    push_scan(make_scan(8'h08));
    repeat (256) push_scan(make_scan(8'h00));
    push_scan(make_scan(8'h04));
    queue_random(30);

    configure(16'hFFFF, 16'd8, 16'd10);
    queue_random(10);

    configure(16'd5000, 16'd3, 16'd0);
    queue_random(40);

    configure(16'd40000, 16'hABC1, 16'd2);
    queue_random(30);

    for (int ph = 0; ph < 5; ph++) begin
      configure(16'($urandom_range(1, 64000)),
                ($urandom_range(0, 4) == 0) ? 16'($urandom_range(9, 15)) :
                                               16'($urandom_range(1, 8)),
                16'($urandom_range(0, 50)));
      queue_random(20);
      if (ph == 0) begin
        pressure_req = 1'b1;
      end
    end

    drain();
    repeat (10) @(negedge clk_i);
    if (expected_gestures.size() != 0) begin
      err_cnt++;
    end
    $display("summary: %0d scans over %0d register settings, %0d results checked",
             scans_taken, settings_cnt, results_checked);
    $display("summary: %0d left and %0d right swipes seen, %0d mismatches",
             lefts_seen, rights_seen, err_cnt);
    if (err_cnt == 0) begin
      $display("tb_touch_slider_swipe_detector_core: done, clean");
    end else begin
      $display("tb_touch_slider_swipe_detector_core: done, errors");
    end
    $finish;
  end

endmodule
